FILE: rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// shared types and constants of the point-in-polygon ray-cast test
// ----------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

    // vertex counter, saturating at the minimum polygon size
    typedef logic [1:0] t_seen;

    localparam t_seen MIN_VERTICES = 2'd3;

    // reset value of the far ray end, truncated to the coordinate width
    localparam int RAY_END_RESET = 9999;

    // orientation of an ordered point triple
    typedef enum logic [1:0] {
        ORI_COL = 2'd0,
        ORI_POS = 2'd1,
        ORI_NEG = 2'd2
    } t_orient;

    // outcome of one edge against the test ray
    typedef struct packed {
        logic hit;      // edge meets the ray
        logic col;      // point is collinear with the edge
        logic on_edge;  // point lies within the edge's bounding box
    } t_edge_res;

endpackage

`default_nettype wire

FILE: rtl/pip_vtx_if.sv
// ----------------------------------------------------------------------------
// pip_vtx_if
// vertex channel: query point, one polygon vertex and the last-vertex flag
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_vtx_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;

    modport source (
        output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pip_res_if.sv
// ----------------------------------------------------------------------------
// pip_res_if
// result channel: inside flag and too-few-vertices flag per polygon
// ----------------------------------------------------------------------------
`default_nettype none

interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;
    logic too_few_vertices;

    modport source (
        output valid, inside_res, too_few_vertices,
        input  ready
    );
    modport sink (
        input  valid, inside_res, too_few_vertices,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/pip_edge.sv
// ----------------------------------------------------------------------------
// pip_edge
// one edge a-b against the horizontal segment from p to (rx, py)
// ----------------------------------------------------------------------------
`default_nettype none

module pip_edge
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic signed [COORD_BITS-1:0] i_ax,
    input  wire logic signed [COORD_BITS-1:0] i_ay,
    input  wire logic signed [COORD_BITS-1:0] i_bx,
    input  wire logic signed [COORD_BITS-1:0] i_by,
    input  wire logic signed [COORD_BITS-1:0] i_px,
    input  wire logic signed [COORD_BITS-1:0] i_py,
    input  wire logic signed [COORD_BITS-1:0] i_rx,
    output t_edge_res                         o_res
);

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    function automatic logic in_range(input logic signed [COORD_BITS-1:0] v,
                                      input logic signed [COORD_BITS-1:0] a,
                                      input logic signed [COORD_BITS-1:0] b);
        return (v >= a && v <= b) || (v >= b && v <= a);
    endfunction

    function automatic t_orient orient(input logic signed [P-1:0] l,
                                       input logic signed [P-1:0] r);
        t_orient o;
        if (l == r) begin
            o = ORI_COL;
        end else if (l < r) begin
            o = ORI_NEG;
        end else begin
            o = ORI_POS;
        end
        return o;
    endfunction

    logic signed [D-1:0] dy_ab, dx_ab, dx_pb, dy_pb, dx_rb;
    logic signed [P-1:0] l1, r1, l2, r2;
    t_orient             d1, d2, d3, d4;
    logic                on_p, on_r, on_a, on_b;

    assign dy_ab = D'(i_by) - D'(i_ay);
    assign dx_ab = D'(i_bx) - D'(i_ax);
    assign dx_pb = D'(i_px) - D'(i_bx);
    assign dy_pb = D'(i_py) - D'(i_by);
    assign dx_rb = D'(i_rx) - D'(i_bx);

    // a, b against p and against the ray end (which shares p's y)
    assign l1 = P'(dy_ab) * P'(dx_pb);
    assign r1 = P'(dx_ab) * P'(dy_pb);
    assign l2 = P'(dy_ab) * P'(dx_rb);
    assign r2 = P'(dx_ab) * P'(dy_pb);

    assign d1 = orient(l1, r1);
    assign d2 = orient(l2, r2);

    // ray is horizontal, so these reduce to sign compares
    assign d3 = (i_rx == i_px || i_ay == i_py) ? ORI_COL :
                (((i_rx > i_px) == (i_ay > i_py)) ? ORI_NEG : ORI_POS);
    assign d4 = (i_rx == i_px || i_by == i_py) ? ORI_COL :
                (((i_rx > i_px) == (i_by > i_py)) ? ORI_NEG : ORI_POS);

    assign on_p = in_range(i_px, i_ax, i_bx) && in_range(i_py, i_ay, i_by);
    assign on_r = in_range(i_rx, i_ax, i_bx) && in_range(i_py, i_ay, i_by);
    assign on_a = in_range(i_ax, i_px, i_rx) && (i_ay == i_py);
    assign on_b = in_range(i_bx, i_px, i_rx) && (i_by == i_py);

    assign o_res.hit = (d1 != d2 && d3 != d4)
                    || (d1 == ORI_COL && on_p)
                    || (d2 == ORI_COL && on_r)
                    || (d3 == ORI_COL && on_a)
                    || (d4 == ORI_COL && on_b);
    // a-p-b collinear is the same triangle as a-b-p
    assign o_res.col     = (d1 == ORI_COL);
    assign o_res.on_edge = on_p;

endmodule

`default_nettype wire

FILE: rtl/point_in_polygon_ray_cast.sv
// ----------------------------------------------------------------------------
// point_in_polygon_ray_cast
// a last vertex goes from the input register through the edge stage into the
// result register, and holds the input register while o_res is held off
// throughput: one vertex item per cycle, set by the single edge stage,
// save that hold; a non-final vertex moves on even while a result waits in o_res
// reset (i_rst_n low, synchronous): pipeline empty, polygon state cleared,
// ray end back to its default of 9999 truncated to the coordinate width
// ----------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_ray_cast
    import pip_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic signed [COORD_BITS-1:0] i_cfg_wdata,
    pip_vtx_if.sink                           i_vtx,
    pip_res_if.source                         o_res
);

    // ---------------- configuration ----------------
    logic signed [COORD_BITS-1:0] r_ray_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_end <= COORD_BITS'(RAY_END_RESET);
        end else if (i_cfg_we) begin
            r_ray_end <= i_cfg_wdata;
        end
    end

    // ---------------- input register ----------------
    logic                         r_in_valid;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_vx, r_vy;
    logic                         r_last;
    logic                         w_take;
    logic                         w_adv;

    // output register
    logic r_out_valid;
    logic r_inside;
    logic r_few;

    // edge stage moves on unless a result is due and the output is blocked
    assign w_adv        = r_in_valid && (!r_last || !r_out_valid || o_res.ready);
    assign i_vtx.ready  = !r_in_valid || w_adv;
    assign w_take       = i_vtx.valid && i_vtx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_px   <= i_vtx.point_x;
            r_py   <= i_vtx.point_y;
            r_vx   <= i_vtx.vertex_x;
            r_vy   <= i_vtx.vertex_y;
            r_last <= i_vtx.last_vertex;
        end
    end

    // ---------------- polygon state ----------------
    logic signed [COORD_BITS-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    t_seen                        r_seen, n_seen;
    logic                         r_par, n_par;
    logic                         r_fix, n_fix;
    logic                         r_fa, n_fa;

    // ---------------- edge tests ----------------
    // edge from previous vertex to this one, and the closing edge to the first
    t_edge_res w_e1, w_e2;

    pip_edge #(.COORD_BITS(COORD_BITS)) u_edge_step (
        .i_ax  (r_prev_x),
        .i_ay  (r_prev_y),
        .i_bx  (r_vx),
        .i_by  (r_vy),
        .i_px  (r_px),
        .i_py  (r_py),
        .i_rx  (r_ray_end),
        .o_res (w_e1)
    );

    pip_edge #(.COORD_BITS(COORD_BITS)) u_edge_close (
        .i_ax  (r_vx),
        .i_ay  (r_vy),
        .i_bx  (r_first_x),
        .i_by  (r_first_y),
        .i_px  (r_px),
        .i_py  (r_py),
        .i_rx  (r_ray_end),
        .o_res (w_e2)
    );

    // ---------------- crossing bookkeeping ----------------
    logic w_few;
    logic w_inside;

    always_comb begin
        n_par = r_par;
        n_fix = r_fix;
        n_fa  = r_fa;

        // first vertex has no edge before it
        if (r_seen != '0 && w_e1.hit) begin
            if (w_e1.col) begin
                // first collinear hit settles the answer for good
                if (!n_fix) begin
                    n_fix = 1'b1;
                    n_fa  = w_e1.on_edge;
                end
            end else begin
                n_par = ~n_par;
            end
        end

        n_seen = (r_seen < MIN_VERTICES) ? r_seen + 2'd1 : r_seen;
        w_few  = (n_seen < MIN_VERTICES);

        // closing edge only on the last vertex of a real polygon
        if (r_last && !w_few && w_e2.hit) begin
            if (w_e2.col) begin
                if (!n_fix) begin
                    n_fix = 1'b1;
                    n_fa  = w_e2.on_edge;
                end
            end else begin
                n_par = ~n_par;
            end
        end

        w_inside = n_fix ? n_fa : n_par;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_par  <= 1'b0;
            r_fix  <= 1'b0;
            r_fa   <= 1'b0;
        end else if (w_adv) begin
            if (r_last) begin
                // polygon done, next item opens a new one
                r_seen <= '0;
                r_par  <= 1'b0;
                r_fix  <= 1'b0;
                r_fa   <= 1'b0;
            end else begin
                r_seen <= n_seen;
                r_par  <= n_par;
                r_fix  <= n_fix;
                r_fa   <= n_fa;
            end
        end
    end

    // vertex coordinates are only read once the counter says they are loaded
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prev_x <= r_vx;
            r_prev_y <= r_vy;
            if (r_seen == '0) begin
                r_first_x <= r_vx;
                r_first_y <= r_vy;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_last) begin
            r_inside <= w_few ? 1'b0 : w_inside;
            r_few    <= w_few;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.inside_res       = r_inside;
    assign o_res.too_few_vertices = r_few;

`ifndef SYNTH
    // a finished polygon leaves a result and a cleared state behind
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_last |=> r_out_valid && r_seen == '0 && !r_par && !r_fix)
        else $error("polygon state not cleared after last vertex");

    // short polygons always report outside
    a_few_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_last && w_few |=> r_few && !r_inside)
        else $error("too-few result carries wrong flags");

    // input stalls only behind a blocked result of a last vertex
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vtx.ready |-> r_in_valid && r_last && r_out_valid && !o_res.ready)
        else $error("input stalled without a blocked result");

    // a non-final vertex never creates a result
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !r_last |=> r_out_valid == $past(r_out_valid && !o_res.ready))
        else $error("result created by a non-final vertex");
`endif

endmodule

`default_nettype wire
